FILE: rtl/lsc_pkg.sv
// Shared types, constants and codes of the line sensor centroid block.
package lsc_pkg;

  localparam int MAX_SENSORS_DEF = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int FUNC_W   = 2;
  localparam int IDX_IN_W = 4;
  localparam int SMP_W    = 10;
  localparam int POS_W    = 11;
  localparam int ACC_W    = 18;
  localparam int CNT_W    = 8;
  localparam int WGT_W    = 14;
  localparam int ACT_W    = 5;
  localparam int STEP_W   = 11;

  localparam int SCOUNT_W = 5;
  localparam int READS_W  = 8;

  localparam int DIV_NUM_W = ACC_W;
  localparam int DIV_DEN_W = READS_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [STEP_W-1:0] STEP_WEIGHT = STEP_W'(100);
  localparam logic [WGT_W-1:0]  WEIGHT_MAX  = '1;
  localparam logic [ACT_W-1:0]  ACTIVE_MAX  = '1;

  localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WHITE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BLACK   = 2'd2;

  localparam logic [1:0] REG_SENSOR_COUNT = 2'd0;
  localparam logic [1:0] REG_LINE_COLOR   = 2'd1;
  localparam logic [1:0] REG_READINGS     = 2'd2;

  localparam logic [SCOUNT_W-1:0] SENSOR_COUNT_RST = SCOUNT_W'(16);
  localparam logic [READS_W-1:0]  READINGS_RST     = READS_W'(100);

  typedef struct packed {
    logic [SCOUNT_W-1:0] sensor_count;
    logic                line_color;
    logic [READS_W-1:0]  readings;
  } cfg_t;

  typedef struct packed {
    logic [SMP_W-1:0] white;
    logic [SMP_W-1:0] black;
    logic [SMP_W-1:0] thr;
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

FILE: rtl/lsc_ram.sv
// Generic single-port RAM with a registered read.
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lsc_div.sv
// Restoring divider that retires one quotient bit per cycle.
module lsc_div import lsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_NUM_W);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_NUM_W-2:0], ge};
      rem_d = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/lsc_regs.sv
// Configuration registers behind the APB port.
module lsc_regs import lsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SENSOR_COUNT: cfg_d.sensor_count = pwdata[SCOUNT_W-1:0];
        REG_LINE_COLOR:   cfg_d.line_color   = pwdata[0];
        REG_READINGS:     cfg_d.readings     = pwdata[READS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SENSOR_COUNT: prdata = APB_DW'(cfg_q.sensor_count);
      REG_LINE_COLOR:   prdata = APB_DW'(cfg_q.line_color);
      REG_READINGS:     prdata = APB_DW'(cfg_q.readings);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_count <= SENSOR_COUNT_RST;
      cfg_q.line_color   <= 1'b0;
      cfg_q.readings     <= READINGS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/line_sensor_centroid_unit.sv
// Top level of the line sensor centroid block: sequencer, sensor RAM and totals.
//
// Channel   Direction  Payload
// s_axis    in         tdata {sample, sensor_index}, tuser func
// m_axis    out        tdata position, tuser line_found
// apb       in/out     sensor_count @0, line_color @4, readings_per_average @8
//
// A measure sample that does not close a pass goes from the read state through the check state
// back to idle, and so does a calibration sample that does not complete an average. A closing
// sample with active sensors, and a calibration sample that completes an average, run the shared
// divider: 18 quotient bits, one per cycle. A closing sample with no active sensor skips it.
// Per-sensor state sits in one RAM that is read for every sample and written back for
// calibration samples; valid bits cleared by reset make unwritten entries read as zero.
// A finished result waits in the output register while the next sample is taken;
// only a closing sample stalls while that register is still full.
module line_sensor_centroid_unit import lsc_pkg::*; #(
  parameter int MAX_SENSORS = MAX_SENSORS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // sensor_index [3:0], sample [13:4]
  input  logic [FUNC_W-1:0] s_axis_tuser,   // func [1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // position [10:0]
  output logic              m_axis_tuser,   // line_found [0]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int IDX_W   = $clog2(MAX_SENSORS);
  localparam int MASK_W  = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
  localparam logic [SMP_W-1:0] SMP_MASK = SMP_W'((33'd1 << MASK_W) - 33'd1);
  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_READ     = 3'd1;
  localparam logic [2:0] ST_CAL_CHK  = 3'd2;
  localparam logic [2:0] ST_MEAS_CHK = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_WB       = 3'd5;
  localparam logic [2:0] ST_OUT      = 3'd6;

  cfg_t cfg;

  logic [2:0]             state_q, state_d;
  logic                   is_meas_q, is_meas_d;
  logic                   is_black_q, is_black_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [SMP_W-1:0]       smp_q, smp_d;
  entry_t                 ent_q, ent_d;
  logic [SMP_W-1:0]       avg_q, avg_d;
  logic [MAX_SENSORS-1:0] valid_q, valid_d;
  logic [WGT_W-1:0]       weight_q, weight_d;
  logic [ACT_W-1:0]       active_q, active_d;
  logic [POS_W-1:0]       res_pos_q, res_pos_d;
  logic                   res_found_q, res_found_d;
  logic                   m_valid_q, m_valid_d;
  logic [POS_W-1:0]       m_pos_q, m_pos_d;
  logic                   m_found_q, m_found_d;

  logic [FUNC_W-1:0]   in_func;
  logic [IDX_IN_W-1:0] in_idx;
  logic [SMP_W-1:0]    in_smp;
  logic                in_acc;
  logic                in_cal;
  logic                in_meas;
  logic [SCOUNT_W-1:0] cnt_eff;
  logic [SCOUNT_W-1:0] last_idx;
  logic [READS_W-1:0]  n_eff;

  logic [IDX_W-1:0]   ram_addr;
  logic               ram_we;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_ent;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  logic                 hit;
  logic [WGT_W:0]       wsum;
  logic [SMP_W:0]       mid_sum;
  logic [SMP_W-1:0]     new_white;
  logic [SMP_W-1:0]     new_black;
  logic                 out_load;

  lsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SENSORS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  lsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign in_func = s_axis_tuser;
  assign in_idx  = s_axis_tdata[IDX_IN_W-1:0];
  assign in_smp  = s_axis_tdata[IDX_IN_W +: SMP_W] & SMP_MASK;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (cfg.sensor_count == '0) begin
      cnt_eff = SCOUNT_W'(1);
    end else if (cfg.sensor_count > SCOUNT_W'(MAX_SENSORS)) begin
      cnt_eff = SCOUNT_W'(MAX_SENSORS);
    end else begin
      cnt_eff = cfg.sensor_count;
    end
  end

  assign last_idx = cnt_eff - SCOUNT_W'(1);
  assign n_eff    = (cfg.readings == '0) ? READS_W'(1) : cfg.readings;

  assign in_cal  = ((in_func == FUNC_WHITE) || (in_func == FUNC_BLACK)) &&
                   ({1'b0, in_idx} < SCOUNT_W'(MAX_SENSORS));
  assign in_meas = (in_func == FUNC_MEASURE) && ({1'b0, in_idx} < cnt_eff);

  assign ram_addr = (state_q == ST_IDLE) ? in_idx[IDX_W-1:0] : idx_q;
  assign rd_ent   = valid_q[idx_q] ? entry_t'(ram_rdata) : '0;

  assign hit = cfg.line_color ? (smp_q > rd_ent.thr) : (smp_q <= rd_ent.thr);
  assign wsum = {1'b0, weight_q} + (WGT_W + 1)'(STEP_W'(idx_q) * STEP_WEIGHT);

  assign new_white = is_black_q ? ent_q.white : avg_q;
  assign new_black = is_black_q ? avg_q : ent_q.black;
  assign mid_sum   = {1'b0, new_white} + {1'b0, new_black};

  assign div_num = (state_q == ST_CAL_CHK) ? ent_q.acc : DIV_NUM_W'(weight_q);
  assign div_den = (state_q == ST_CAL_CHK) ? n_eff : DIV_DEN_W'(active_q);

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    is_meas_d   = is_meas_q;
    is_black_d  = is_black_q;
    idx_d       = idx_q;
    smp_d       = smp_q;
    ent_d       = ent_q;
    avg_d       = avg_q;
    valid_d     = valid_q;
    weight_d    = weight_q;
    active_d    = active_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    ram_we      = 1'b0;
    ram_wdata   = ent_q;
    div_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_cal || in_meas)) begin
          is_meas_d  = in_meas;
          is_black_d = (in_func == FUNC_BLACK);
          idx_d      = in_idx[IDX_W-1:0];
          smp_d      = in_smp;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        if (is_meas_q) begin
          if (hit) begin
            weight_d = wsum[WGT_W] ? WEIGHT_MAX : wsum[WGT_W-1:0];
            if (active_q != ACTIVE_MAX) begin
              active_d = active_q + ACT_W'(1);
            end
          end
          state_d = ST_MEAS_CHK;
        end else begin
          ent_d     = rd_ent;
          ent_d.acc = rd_ent.acc + ACC_W'(smp_q);
          ent_d.cnt = rd_ent.cnt + CNT_W'(1);
          state_d   = ST_CAL_CHK;
        end
      end
      ST_CAL_CHK: begin
        if (ent_q.cnt < n_eff) begin
          ram_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_MEAS_CHK: begin
        if (SCOUNT_W'(idx_q) != last_idx) begin
          state_d = ST_IDLE;
        end else if (active_q == '0) begin
          res_pos_d   = '0;
          res_found_d = 1'b0;
          state_d     = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (is_meas_q) begin
            res_pos_d   = div_quo[POS_W-1:0];
            res_found_d = 1'b1;
            state_d     = ST_OUT;
          end else begin
            avg_d   = div_quo[SMP_W-1:0] & SMP_MASK;
            state_d = ST_WB;
          end
        end
      end
      ST_WB: begin
        ram_wdata.white = new_white;
        ram_wdata.black = new_black;
        ram_wdata.thr   = mid_sum[SMP_W:1];
        ram_wdata.acc   = '0;
        ram_wdata.cnt   = '0;
        ram_we          = 1'b1;
        valid_d[idx_q]  = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_OUT: begin
        if (out_load) begin
          weight_d = '0;
          active_d = '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_pos_d   = m_pos_q;
    m_found_d = m_found_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_pos_d   = res_pos_q;
      m_found_d = res_found_q;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      weight_q  <= '0;
      active_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      weight_q  <= weight_d;
      active_q  <= active_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_meas_q   <= is_meas_d;
    is_black_q  <= is_black_d;
    idx_q       <= idx_d;
    smp_q       <= smp_d;
    ent_q       <= ent_d;
    avg_q       <= avg_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    m_pos_q     <= m_pos_d;
    m_found_q   <= m_found_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 16'(m_pos_q);
  assign m_axis_tuser  = m_found_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> state_q == ST_IDLE)
    else $error("Sample accepted while the sequencer was busy.");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("Divider started while still running.");

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !m_valid_q || m_axis_tready)
    else $error("Result loaded over a pending one.");

  a_no_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("Position is not zero when no line was found.");

  a_write_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> state_q == ST_IDLE)
    else $error("RAM write-back not followed by idle.");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the line sensor centroid unit, with directed and random sample streams.
module testbench;
  import lsc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } centroid_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;   // sensor_index [3:0], sample [13:4]
  logic [FUNC_W-1:0] s_axis_tuser = '0;   // func [1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // position [10:0]
  logic              m_axis_tuser;        // line_found [0]
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic [SCOUNT_W-1:0] cfg_count = SENSOR_COUNT_RST;
  logic                cfg_color = 1'b0;
  logic [READS_W-1:0]  cfg_reads = READINGS_RST;

  logic [SMP_W-1:0] white_avg [MAX_SENSORS_DEF] = '{default: '0};
  logic [SMP_W-1:0] black_avg [MAX_SENSORS_DEF] = '{default: '0};
  logic [SMP_W-1:0] sensor_thr [MAX_SENSORS_DEF] = '{default: '0};
  logic [ACC_W-1:0] calib_acc [MAX_SENSORS_DEF] = '{default: '0};
  logic [CNT_W-1:0] calib_cnt [MAX_SENSORS_DEF] = '{default: '0};
  logic [WGT_W-1:0] weight_sum = '0;
  logic [ACT_W-1:0] active_sum = '0;

  centroid_t centroid_q [$];
  int errors = 0;
  int item_total = 0;
  int cycles = 0;
  int src_idle_pct = 38;
  int sink_idle_pct = 48;

  line_sensor_centroid_unit DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    centroid_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (centroid_q.size() == 0) begin
        $error("unexpected result: position %0d line_found %0d", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = centroid_q.pop_front();
        if (m_axis_tdata !== 16'(want.position)) begin
          $error("position: expected %0d, actual %0d", want.position, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.found) begin
          $error("line_found: expected %0d, actual %0d", want.found, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  function automatic int eff_sensors();
    if (cfg_count == 0) return 1;
    if (cfg_count > MAX_SENSORS_DEF) return MAX_SENSORS_DEF;
    return int'(cfg_count);
  endfunction

  task automatic predict_centroid(input logic [FUNC_W-1:0] fn, input logic [3:0] idx,
                                  input logic [SMP_W-1:0] smp, output bit taken);
    int n;
    int wsum;
    bit active;
    centroid_t res;
    taken = 1'b0;
    if (fn == FUNC_WHITE || fn == FUNC_BLACK) begin
      taken = 1'b1;
      n = (cfg_reads == 0) ? 1 : int'(cfg_reads);
      calib_acc[idx] = calib_acc[idx] + ACC_W'(smp);
      calib_cnt[idx] = calib_cnt[idx] + 1'b1;
      if (int'(calib_cnt[idx]) >= n) begin
        if (fn == FUNC_BLACK) black_avg[idx] = SMP_W'(int'(calib_acc[idx]) / n);
        else white_avg[idx] = SMP_W'(int'(calib_acc[idx]) / n);
        calib_acc[idx] = '0;
        calib_cnt[idx] = '0;
        sensor_thr[idx] = SMP_W'((int'(white_avg[idx]) + int'(black_avg[idx])) / 2);
      end
    end else if (fn == FUNC_MEASURE && int'(idx) < eff_sensors()) begin
      taken = 1'b1;
      active = cfg_color ? (smp > sensor_thr[idx]) : (smp <= sensor_thr[idx]);
      if (active) begin
        wsum = int'(weight_sum) + int'(idx) * int'(STEP_WEIGHT);
        weight_sum = (wsum > int'(WEIGHT_MAX)) ? WEIGHT_MAX : WGT_W'(wsum);
        if (active_sum != ACTIVE_MAX) active_sum = active_sum + 1'b1;
      end
      if (int'(idx) == eff_sensors() - 1) begin
        res.position = (active_sum != 0) ? POS_W'(weight_sum / active_sum) : '0;
        res.found = (active_sum != 0);
        centroid_q.push_back(res);
        weight_sum = '0;
        active_sum = '0;
      end
    end
  endtask

  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [3:0] idx,
                           input logic [SMP_W-1:0] smp);
    bit taken;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {2'b00, smp, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_centroid(fn, idx, smp, taken);
    if (taken) item_total++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (centroid_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] ridx, input logic [APB_DW-1:0] val);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {ridx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (ridx)
      REG_SENSOR_COUNT: cfg_count = val[SCOUNT_W-1:0];
      REG_LINE_COLOR:   cfg_color = val[0];
      REG_READINGS:     cfg_reads = val[READS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [SMP_W-1:0] near_threshold(input logic [3:0] idx);
    int v;
    v = int'(sensor_thr[idx]) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SMP_W'(v);
  endfunction

  task automatic test_reset_state();
    send_item(FUNC_MEASURE, 4'd0, 10'd0);
    send_item(FUNC_MEASURE, 4'd7, 10'd1023);
    send_item(FUNC_MEASURE, 4'd15, 10'd0);
  endtask

  task automatic test_ignored_items();
    send_item(FUNC_UNUSED, 4'd15, 10'd1023);
    send_item(FUNC_UNUSED, 4'd0, 10'd0);
  endtask

  task automatic test_count_limits();
    reg_write(REG_SENSOR_COUNT, 32'd0);
    send_item(FUNC_MEASURE, 4'd1, 10'd0);
    send_item(FUNC_MEASURE, 4'd0, 10'd1023);
    reg_write(REG_SENSOR_COUNT, 32'd31);
    send_item(FUNC_MEASURE, 4'd15, 10'd0);
  endtask

  task automatic test_calibration_cases();
    reg_write(REG_READINGS, 32'd0);
    reg_write(REG_SENSOR_COUNT, 32'd4);
    send_item(FUNC_WHITE, 4'd2, 10'd1023);
    send_item(FUNC_BLACK, 4'd2, 10'd0);
    reg_write(REG_READINGS, 32'd2);
    // The second sample switches color, so it decides which average is written.
    send_item(FUNC_WHITE, 4'd3, 10'd1000);
    send_item(FUNC_BLACK, 4'd3, 10'd20);
    reg_write(REG_LINE_COLOR, 32'd1);
    send_item(FUNC_MEASURE, 4'd0, 10'd0);
    send_item(FUNC_MEASURE, 4'd2, 10'd512);
    send_item(FUNC_MEASURE, 4'd3, 10'd511);
  endtask

  task automatic test_full_average();
    reg_write(REG_READINGS, 32'd255);
    reg_write(REG_SENSOR_COUNT, 32'd16);
    repeat (255) send_item(FUNC_WHITE, 4'd9, SMP_W'($urandom_range(1016, 1023)));
    for (int i = 0; i < 16; i++) send_item(FUNC_MEASURE, 4'(i), near_threshold(4'(i)));
  endtask

  task automatic configure_random();
    logic [APB_DW-1:0] cnt_val;
    logic [APB_DW-1:0] reads_val;
    case ($urandom_range(0, 9))
      0: cnt_val = 0;
      1: cnt_val = $urandom_range(17, 31);
      2: cnt_val = 1;
      3: cnt_val = 16;
      default: cnt_val = $urandom_range(2, 15);
    endcase
    case ($urandom_range(0, 9))
      0: reads_val = 0;
      1: reads_val = 1;
      default: reads_val = $urandom_range(1, 4);
    endcase
    reg_write(REG_SENSOR_COUNT, cnt_val);
    reg_write(REG_LINE_COLOR, APB_DW'($urandom_range(0, 1)));
    reg_write(REG_READINGS, reads_val);
  endtask

  task automatic test_random_traffic(input int n_items);
    int target;
    int next_cfg;
    int n;
    int reps;
    logic [3:0] idx;
    logic [FUNC_W-1:0] fn;
    logic [SMP_W-1:0] smp;
    target = item_total + n_items;
    next_cfg = item_total;
    while (item_total < target) begin
      if (item_total >= next_cfg) begin
        configure_random();
        next_cfg = item_total + $urandom_range(40, 90);
      end
      case ($urandom_range(0, 99)) inside
        [0:24]: begin
          idx = 4'($urandom_range(0, 15));
          fn = $urandom_range(0, 1) ? FUNC_WHITE : FUNC_BLACK;
          n = (cfg_reads == 0) ? 1 : int'(cfg_reads);
          for (int k = 0; k < n; k++) begin
            if (k == n - 1 && $urandom_range(0, 4) == 0)
              fn = (fn == FUNC_WHITE) ? FUNC_BLACK : FUNC_WHITE;
            if ($urandom_range(0, 9) == 0) smp = SMP_W'($urandom_range(0, 1023));
            else if (fn == FUNC_WHITE) smp = SMP_W'($urandom_range(500, 1023));
            else smp = SMP_W'($urandom_range(0, 520));
            send_item(fn, idx, smp);
          end
        end
        [25:74]: begin
          for (int i = 0; i < eff_sensors(); i++) begin
            case ($urandom_range(0, 9))
              0: smp = 10'd0;
              1: smp = 10'd1023;
              2, 3, 4, 5: smp = near_threshold(4'(i));
              default: smp = SMP_W'($urandom_range(0, 1023));
            endcase
            if (i == eff_sensors() - 1 || $urandom_range(0, 9) != 0)
              send_item(FUNC_MEASURE, 4'(i), smp);
            if (i < eff_sensors() - 1 && $urandom_range(0, 19) == 0)
              send_item(FUNC_MEASURE, 4'(i), smp);
          end
        end
        [75:84]: begin
          idx = 4'($urandom_range(0, eff_sensors() - 1));
          reps = $urandom_range(5, 40);
          repeat (reps) send_item(FUNC_MEASURE, idx, cfg_color ? 10'd1023 : 10'd0);
          send_item(FUNC_MEASURE, 4'(eff_sensors() - 1), SMP_W'($urandom_range(0, 1023)));
        end
        default: begin
          repeat ($urandom_range(1, 3))
            send_item(FUNC_W'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      SMP_W'($urandom_range(0, 1023)));
        end
      endcase
      if ($urandom_range(0, 29) == 0) wait_idle();
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_ignored_items();
    test_count_limits();
    test_calibration_cases();
    test_full_average();
    src_idle_pct = 38;
    sink_idle_pct = 48;
    test_random_traffic(200);
    src_idle_pct = 48;
    sink_idle_pct = 38;
    test_random_traffic(200);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(200);
    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
